/* sv/bbma_pkg.sv */
// ----------------------------------------------------------------------------
// bbma_pkg
// Shared constants, types and helpers for the bounded byte memory access block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbma_pkg;

  localparam int DEPTH_DEFAULT = 65536;
  localparam int SIZE_W        = 17;
  localparam int SIZE_RESET    = 65536;
  localparam int RND_W         = SIZE_W + 1;
  localparam int NUM_LANES     = 4;

  localparam logic [7:0] FILL_BYTE = 8'ha5;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;
  localparam logic [1:0] WIDTH_WORD = 2'd2;

  // Per-lane enables (in range and part of the access) and the range flag.
  typedef struct packed {
    logic [NUM_LANES-1:0] en;
    logic                 bad;
  } lane_ctl_t;

  // True when byte k of the access belongs to an access of the given width.
  // The unused width code behaves as a word.
  function automatic logic lane_active(input logic [1:0] wcode, input logic [1:0] k);
    logic act;
    unique case (wcode)
      WIDTH_BYTE: act = (k == 2'd0);
      WIDTH_HALF: act = (k[1] == 1'b0);
      default:    act = 1'b1;
    endcase
    return act;
  endfunction

endpackage

`default_nettype wire

/* sv/bounded_byte_memory_access.sv */
// ----------------------------------------------------------------------------
// bounded_byte_memory_access
// Byte-addressed little-endian memory with a configurable limit; accesses of
// 1, 2 or 4 bytes at any alignment, served by four byte banks.
// ----------------------------------------------------------------------------
//
//   Port group   Handshake           Carries
//   in_*         in_valid/in_ready   op, access_width, sign_extend, addr, data
//   out_*        out_valid/out_ready read_data, out_of_range
//   cfg_*        cfg_wr_en           size_in_use (17 bits)
//
// One item per cycle while no result is stalled and no clearing pass runs; each
// item passes through the input register, the bank read register and the result
// register in turn.
// After reset a clearing pass fills the banks with 0xa5, one row of four bytes
// per cycle, over all (DEPTH+3)/4 rows; in_ready stays low meanwhile.
// A stalled result holds the whole pipe; the input register still takes an
// item while it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_byte_memory_access #(
  parameter int DEPTH = bbma_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_op,
  input  wire logic [1:0]                  in_access_width,
  input  wire logic                        in_sign_extend,
  input  wire logic [31:0]                 in_addr,
  input  wire logic [31:0]                 in_write_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [31:0]                      out_read_data,
  output logic                             out_out_of_range,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bbma_pkg::SIZE_W-1:0] cfg_wr_data
);
  import bbma_pkg::*;

  localparam int ROWS  = (DEPTH + 3) / 4;
  localparam int ROW_W = $clog2(ROWS);
  localparam int LW    = ($clog2(DEPTH + 1) > RND_W) ? $clog2(DEPTH + 1) : RND_W;
  localparam logic [LW-1:0]    DEPTH_L     = LW'(DEPTH);
  localparam logic [LW-1:0]    LIMIT_RESET = (SIZE_RESET > DEPTH) ? LW'(DEPTH)
                                                                  : LW'(SIZE_RESET);
  localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

  // Limit register, already rounded and clamped.
  logic [LW-1:0]    limit_r, limit_nxt;
  logic [RND_W-1:0] rnd;
  logic [LW-1:0]    rnd_ext;

  // Clearing pass.
  logic             clr_r;
  logic [ROW_W-1:0] clr_row_r;

  // Input stage.
  logic        a_valid_r;
  logic        a_op_r;
  logic [1:0]  a_wcode_r;
  logic        a_sx_r;
  logic [31:0] a_addr_r;
  logic [31:0] a_wdata_r;

  // Bank read stage.
  logic       b_valid_r;
  logic       b_op_r;
  logic [1:0] b_wcode_r;
  logic       b_sx_r;
  logic [1:0] b_lo_r;
  lane_ctl_t  b_ctl_r;

  // Result stage.
  logic        out_valid_r;
  logic [31:0] out_read_data_r;
  logic        out_bad_r;

  logic                  adv;
  logic                  in_acc;
  logic [3:0][ROW_W-1:0] lane_row;
  logic [3:0][7:0]       lane_wbyte;
  lane_ctl_t             lane_ctl;
  logic [3:0][7:0]       bank_rd;
  logic [31:0]           merged;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !clr_r && (!a_valid_r || adv);
  assign in_acc   = in_valid && in_ready;

  assign rnd       = ({1'b0, cfg_wr_data} + RND_W'(15)) & ~RND_W'(15);
  assign rnd_ext   = LW'(rnd);
  assign limit_nxt = (rnd_ext > DEPTH_L) ? DEPTH_L : rnd_ext;

  bbma_lane_map #(
    .ROW_W (ROW_W)
  ) u_lane_map (
    .wcode (a_wcode_r),
    .addr  (a_addr_r),
    .wdata (a_wdata_r),
    .limit (32'(limit_r)),
    .row   (lane_row),
    .wbyte (lane_wbyte),
    .ctl   (lane_ctl)
  );

  for (genvar b = 0; b < NUM_LANES; b++) begin : g_bank
    bbma_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .en    (clr_r || (adv && a_valid_r && lane_ctl.en[b])),
      .we    (clr_r || (a_op_r == OP_WRITE)),
      .addr  (clr_r ? clr_row_r : lane_row[b]),
      .wdata (clr_r ? FILL_BYTE : lane_wbyte[b]),
      .rdata (bank_rd[b])
    );
  end

  bbma_merge u_merge (
    .op        (b_op_r),
    .wcode     (b_wcode_r),
    .sx        (b_sx_r),
    .lo        (b_lo_r),
    .en        (b_ctl_r.en),
    .rd        (bank_rd),
    .read_data (merged)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      clr_r       <= 1'b1;
      clr_row_r   <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= limit_nxt;
      end
      if (clr_r) begin
        clr_row_r <= clr_row_r + 1'b1;
        if (clr_row_r == LAST_ROW) begin
          clr_r <= 1'b0;
        end
      end
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (adv) begin
        a_valid_r <= 1'b0;
      end
      if (adv) begin
        b_valid_r   <= a_valid_r;
        out_valid_r <= b_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r    <= in_op;
      a_wcode_r <= in_access_width;
      a_sx_r    <= in_sign_extend;
      a_addr_r  <= in_addr;
      a_wdata_r <= in_write_data;
    end
    if (adv) begin
      b_op_r          <= a_op_r;
      b_wcode_r       <= a_wcode_r;
      b_sx_r          <= a_sx_r;
      b_lo_r          <= a_addr_r[1:0];
      b_ctl_r         <= lane_ctl;
      out_read_data_r <= merged;
      out_bad_r       <= b_ctl_r.bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_out_of_range = out_bad_r;

endmodule

`default_nettype wire

/* sv/bbma_lane_map.sv */
// ----------------------------------------------------------------------------
// bbma_lane_map
// Steers the bytes of one access onto the four byte banks and range-checks
// every byte address on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module bbma_lane_map #(
  parameter int ROW_W = 14
) (
  input  wire logic [1:0]              wcode,
  input  wire logic [31:0]             addr,
  input  wire logic [31:0]             wdata,
  input  wire logic [31:0]             limit,
  output logic [3:0][ROW_W-1:0]        row,
  output logic [3:0][7:0]              wbyte,
  output bbma_pkg::lane_ctl_t          ctl
);
  import bbma_pkg::*;

  always_comb begin
    logic [1:0]  kb;
    logic [31:0] ab;
    logic [31:0] sh;
    logic        act;
    logic        inr;
    ctl = '0;
    for (int b = 0; b < NUM_LANES; b++) begin
      // Bank b holds the byte whose address has low bits equal to b.
      kb       = 2'(b) - addr[1:0];
      ab       = addr + {30'b0, kb};
      sh       = wdata >> {kb, 3'b000};
      act      = lane_active(wcode, kb);
      inr      = (ab < limit);
      row[b]   = ab[ROW_W+1:2];
      wbyte[b] = sh[7:0];
      ctl.en[b] = act & inr;
      ctl.bad   = ctl.bad | (act & ~inr);
    end
  end

endmodule

`default_nettype wire

/* sv/bbma_bank.sv */
// ----------------------------------------------------------------------------
// bbma_bank
// One byte-wide bank: single port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbma_bank #(
  parameter int ROWS  = 16384,
  parameter int ROW_W = 14
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [ROW_W-1:0] addr,
  input  wire logic [7:0]       wdata,
  output logic [7:0]            rdata
);

  logic [7:0] mem_r [ROWS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/bbma_merge.sv */
// ----------------------------------------------------------------------------
// bbma_merge
// Assembles bank read bytes little-endian, sign-extends; writes return zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bbma_merge (
  input  wire logic                op,
  input  wire logic [1:0]          wcode,
  input  wire logic                sx,
  input  wire logic [1:0]          lo,
  input  wire logic [3:0]          en,
  input  wire logic [3:0][7:0]     rd,
  output logic [31:0]              read_data
);
  import bbma_pkg::*;

  always_comb begin
    logic [1:0]  lane;
    logic [31:0] val;
    val = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane = lo + 2'(k);
      // Banks outside the access or beyond the limit were not enabled.
      val[8*k +: 8] = en[lane] ? rd[lane] : 8'h00;
    end
    if (op == OP_WRITE) begin
      read_data = '0;
    end else if (sx) begin
      unique case (wcode)
        WIDTH_BYTE: read_data = {{24{val[7]}}, val[7:0]};
        WIDTH_HALF: read_data = {{16{val[15]}}, val[15:0]};
        default:    read_data = val;
      endcase
    end else begin
      read_data = val;
    end
  end

endmodule

`default_nettype wire
